### rtl/core/itrt_pkg.sv
// itrt_pkg: shared constants, types and the glyph lookup for integer_to_radix_text.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itrt_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int RADIX_W        = 5;
  localparam int GLYPHS_W       = 64;
  localparam int CFG_IDX_W      = 2;
  localparam int DIGIT_W        = 4;
  localparam int GLYPH_W        = 8;
  localparam int STEP_BITS      = 4;

  localparam logic [RADIX_W-1:0]  RADIX_RESET       = 5'd10;
  localparam logic [RADIX_W-1:0]  RADIX_MIN         = 5'd2;
  localparam logic [RADIX_W-1:0]  RADIX_MAX         = 5'd16;
  localparam logic [GLYPHS_W-1:0] GLYPHS_LOW_RESET  = 64'h3736_3534_3332_3130;
  localparam logic [GLYPHS_W-1:0] GLYPHS_HIGH_RESET = 64'h0000_0000_0000_3938;
  localparam logic [GLYPH_W-1:0]  MINUS_GLYPH       = 8'h2D;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX       = 2'd0,
    CFG_GLYPHS_LOW  = 2'd1,
    CFG_GLYPHS_HIGH = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [DIGIT_W-1:0] digit,
                                                  input logic [GLYPHS_W-1:0] lo,
                                                  input logic [GLYPHS_W-1:0] hi);
    logic [GLYPHS_W-1:0] word;
    word = digit[3] ? hi : lo;
    return word[{digit[2:0], 3'b000} +: GLYPH_W];
  endfunction

endpackage

`default_nettype wire

### rtl/core/itrt_ifs.sv
// Valid/ready channel interfaces for integer_to_radix_text: input, result, config.
// Depends on itrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface itrt_in_if #(parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEF);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [VALUE_BITS-1:0] value;
  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface itrt_out_if;
  logic                          valid;
  logic                          ready;
  logic [itrt_pkg::GLYPH_W-1:0]  glyph;
  logic                          last;
  modport source (output valid, glyph, last, input ready);
  modport sink   (input valid, glyph, last, output ready);
endinterface

interface itrt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [itrt_pkg::CFG_IDX_W-1:0] index;
  logic [itrt_pkg::GLYPHS_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/itrt_cfg_regs.sv
// itrt_cfg_regs: radix and glyph table registers, radix clamped to 2..16.
// Depends on itrt_pkg and itrt_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module itrt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  itrt_cfg_if.sink                       cfg,
  output logic [itrt_pkg::RADIX_W-1:0]   radix_eff,
  output logic [itrt_pkg::GLYPHS_W-1:0]  glyphs_lo,
  output logic [itrt_pkg::GLYPHS_W-1:0]  glyphs_hi
);

  logic [itrt_pkg::RADIX_W-1:0]  radix_r;
  logic [itrt_pkg::GLYPHS_W-1:0] glyphs_lo_r;
  logic [itrt_pkg::GLYPHS_W-1:0] glyphs_hi_r;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= itrt_pkg::RADIX_RESET;
      glyphs_lo_r <= itrt_pkg::GLYPHS_LOW_RESET;
      glyphs_hi_r <= itrt_pkg::GLYPHS_HIGH_RESET;
    end else if (cfg.valid) begin
      case (itrt_pkg::cfg_reg_t'(cfg.index))
        itrt_pkg::CFG_RADIX:       radix_r     <= cfg.data[itrt_pkg::RADIX_W-1:0];
        itrt_pkg::CFG_GLYPHS_LOW:  glyphs_lo_r <= cfg.data;
        itrt_pkg::CFG_GLYPHS_HIGH: glyphs_hi_r <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (radix_r < itrt_pkg::RADIX_MIN) begin
      radix_eff = itrt_pkg::RADIX_MIN;
    end else if (radix_r > itrt_pkg::RADIX_MAX) begin
      radix_eff = itrt_pkg::RADIX_MAX;
    end else begin
      radix_eff = radix_r;
    end
  end

  assign glyphs_lo = glyphs_lo_r;
  assign glyphs_hi = glyphs_hi_r;

endmodule

`default_nettype wire

### rtl/core/itrt_div.sv
// itrt_div: iterative divider by a small radix, STEP_BITS quotient bits per cycle.
// Depends on itrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itrt_div #(
  parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  itrt_pkg::div_ctrl_t           ctrl,
  input  logic [VALUE_BITS-1:0]         dividend,
  input  logic [itrt_pkg::RADIX_W-1:0]  radix,
  output logic [VALUE_BITS-1:0]         quotient,
  output logic [itrt_pkg::DIGIT_W-1:0]  remainder,
  output itrt_pkg::div_stat_t           stat
);

  localparam int STEPS = (VALUE_BITS + itrt_pkg::STEP_BITS - 1) / itrt_pkg::STEP_BITS;
  localparam int DW    = STEPS * itrt_pkg::STEP_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DW-1:0]                  q_r;
  logic [itrt_pkg::DIGIT_W-1:0]   rem_r;
  logic [CNT_W-1:0]               cnt_r;
  logic                           done_r;
  logic [DW-1:0]                  step_q;
  logic [itrt_pkg::RADIX_W-1:0]   step_rem;

  // restoring division, STEP_BITS bits per cycle; partial remainder stays below radix
  always_comb begin
    step_q   = q_r;
    step_rem = {1'b0, rem_r};
    for (int i = 0; i < itrt_pkg::STEP_BITS; i++) begin
      step_rem = {step_rem[itrt_pkg::DIGIT_W-1:0], step_q[DW-1]};
      step_q   = {step_q[DW-2:0], 1'b0};
      if (step_rem >= radix) begin
        step_rem  = step_rem - radix;
        step_q[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (ctrl.start) begin
      cnt_r  <= CNT_W'(STEPS);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      q_r   <= DW'(dividend);
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      q_r   <= step_q;
      rem_r <= step_rem[itrt_pkg::DIGIT_W-1:0];
    end
  end

  assign quotient  = q_r[VALUE_BITS-1:0];
  assign remainder = rem_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

`default_nettype wire

### rtl/core/integer_to_radix_text.sv
// integer_to_radix_text: prints a signed or unsigned number as radix text.
// Depends on itrt_pkg, itrt_ifs, itrt_cfg_regs and itrt_div.
//
// Use: in_chan carries kind (0 signed, 1 unsigned) and value. Each transfer
// produces a run of characters on out_chan, most significant digit first, led
// by '-' for a negative signed value; last marks the final character.
// cfg_chan writes radix (index 0, clamped to 2..16), glyphs_low (1) and
// glyphs_high (2); it is always ready. The user must write it only while
// idle; the block itself does not enforce this. Timing: digits come from
// one shared divider retiring 4 quotient bits per cycle, one division per
// digit. The number then loads one character per cycle into the output
// register while the receiver keeps up. in_chan.ready is low from the input
// transfer until the final character is loaded; a stalled receiver holds
// the output register and the character sequencer waits behind it.
// Reset: idle, output empty, radix 10, glyph table "0123456789".
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_text #(
  parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  itrt_in_if.sink    in_chan,
  itrt_out_if.source out_chan,
  itrt_cfg_if.sink   cfg_chan
);

  localparam int STACK_W = VALUE_BITS * itrt_pkg::DIGIT_W;
  localparam int CNT_W   = $clog2(VALUE_BITS + 1);

  itrt_pkg::state_t               state_r, state_nxt;
  logic                           minus_r, minus_nxt;
  logic [STACK_W-1:0]             stack_r, stack_nxt;
  logic [CNT_W-1:0]               ndig_r, ndig_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [itrt_pkg::GLYPH_W-1:0]   glyph_r, glyph_nxt;
  logic                           last_r, last_nxt;

  logic [itrt_pkg::RADIX_W-1:0]   radix_eff;
  logic [itrt_pkg::GLYPHS_W-1:0]  glyphs_lo;
  logic [itrt_pkg::GLYPHS_W-1:0]  glyphs_hi;

  itrt_pkg::div_ctrl_t            div_ctrl;
  itrt_pkg::div_stat_t            div_stat;
  logic [VALUE_BITS-1:0]          div_dividend;
  logic [VALUE_BITS-1:0]          div_quot;
  logic [itrt_pkg::DIGIT_W-1:0]   div_rem;

  logic                           in_ready;
  logic                           in_fire;
  logic                           value_neg;
  logic [VALUE_BITS-1:0]          value_mag;
  logic                           push;
  logic                           load;
  logic                           pop;

  itrt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_chan),
    .radix_eff (radix_eff),
    .glyphs_lo (glyphs_lo),
    .glyphs_hi (glyphs_hi)
  );

  itrt_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (div_ctrl),
    .dividend  (div_dividend),
    .radix     (radix_eff),
    .quotient  (div_quot),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  assign value_neg = !in_chan.kind && in_chan.value[VALUE_BITS-1];
  assign value_mag = value_neg ? (~in_chan.value + VALUE_BITS'(1)) : in_chan.value;

  // sequencer outputs
  always_comb begin
    in_ready       = (state_r == itrt_pkg::ST_IDLE);
    in_fire        = in_chan.valid && in_ready;
    push           = (state_r == itrt_pkg::ST_DIV) && div_stat.done;
    div_ctrl.start = in_fire || (push && (div_quot != '0));
    div_dividend   = in_fire ? value_mag : div_quot;
    load           = (state_r == itrt_pkg::ST_EMIT) && (!out_valid_r || out_chan.ready);
    pop            = load && !minus_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itrt_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = itrt_pkg::ST_DIV;
        end
      end
      itrt_pkg::ST_DIV: begin
        if (push && (div_quot == '0)) begin
          state_nxt = itrt_pkg::ST_EMIT;
        end
      end
      itrt_pkg::ST_EMIT: begin
        if (pop && (ndig_r == CNT_W'(1))) begin
          state_nxt = itrt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = itrt_pkg::ST_IDLE;
    endcase
  end

  // digit stack (last pushed digit in the low nibble) and output register
  always_comb begin
    minus_nxt     = minus_r;
    stack_nxt     = stack_r;
    ndig_nxt      = ndig_r;
    out_valid_nxt = out_valid_r;
    glyph_nxt     = glyph_r;
    last_nxt      = last_r;
    if (in_fire) begin
      minus_nxt = value_neg;
      ndig_nxt  = '0;
    end
    if (push) begin
      stack_nxt = {stack_r[STACK_W-itrt_pkg::DIGIT_W-1:0], div_rem};
      ndig_nxt  = ndig_r + CNT_W'(1);
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      if (minus_r) begin
        glyph_nxt = itrt_pkg::MINUS_GLYPH;
        last_nxt  = 1'b0;
        minus_nxt = 1'b0;
      end else begin
        glyph_nxt = itrt_pkg::glyph_of(stack_r[itrt_pkg::DIGIT_W-1:0], glyphs_lo, glyphs_hi);
        last_nxt  = (ndig_r == CNT_W'(1));
        stack_nxt = stack_r >> itrt_pkg::DIGIT_W;
        ndig_nxt  = ndig_r - CNT_W'(1);
      end
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itrt_pkg::ST_IDLE;
      minus_r     <= 1'b0;
      ndig_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      minus_r     <= minus_nxt;
      ndig_r      <= ndig_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stack_r <= stack_nxt;
    glyph_r <= glyph_nxt;
    last_r  <= last_nxt;
  end

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.glyph = glyph_r;
  assign out_chan.last  = last_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input taken while a number is in progress");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == itrt_pkg::ST_DIV)
    else $error("divider running outside the digit phase");

  a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == itrt_pkg::ST_EMIT && !minus_r |-> ndig_r != '0)
    else $error("emit phase with an empty digit stack");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ndig_r <= CNT_W'(VALUE_BITS))
    else $error("digit count beyond the value width");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.last |-> state_r != itrt_pkg::ST_EMIT || ndig_r == '0 ||
      $past(state_r) != itrt_pkg::ST_EMIT || !$past(minus_r) || !$past(load))
    else $error("minus sign flagged as final character");

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for integer_to_radix_text: directed table, then random phases.
// Each transfer is checked against the row's expected text or an in-bench radix text predictor.
// Depends on itrt_pkg, itrt_ifs and the integer_to_radix_text RTL.
`timescale 1ns / 1ps

module testbench;
  import itrt_pkg::*;

  localparam int  VALUE_BITS       = VALUE_BITS_DEF;
  localparam int  LIMIT_CYCLES     = 1000000;
  localparam int  SETTLE_CYCLES    = 4;
  localparam int  RANDOM_PHASES    = 6;
  localparam int  ITEMS_PER_PHASE  = 16;
  localparam logic KIND_SIGNED     = 1'b0;
  localparam logic KIND_UNSIGNED   = 1'b1;
  localparam logic [GLYPHS_W-1:0] HEX_UPPER_HIGH = 64'h4645_4443_4241_3938;
  localparam logic [GLYPHS_W-1:0] HEX_LOWER_HIGH = 64'h6665_6463_6261_3938;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic               last;
  } text_char_t;

  typedef struct {
    bit                    is_write;
    cfg_reg_t              reg_idx;
    logic [GLYPHS_W-1:0]   data;
    logic                  kind;
    logic [VALUE_BITS-1:0] value;
    string                 text;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  int   error_count = 0;
  int   cycle_count = 0;
  int   stall_left = 0;
  bit   steady = 1'b0;

  logic [RADIX_W-1:0]  radix_reg;
  logic [GLYPHS_W-1:0] glyphs_lo_reg;
  logic [GLYPHS_W-1:0] glyphs_hi_reg;
  text_char_t          pending_chars[$];
  stim_row_t           directed_rows[$];

  itrt_in_if #(.VALUE_BITS(VALUE_BITS)) in_chan();
  itrt_out_if out_chan();
  itrt_cfg_if cfg_chan();

  integer_to_radix_text #(.VALUE_BITS(VALUE_BITS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom;
      3:       v = $urandom_range(0, 40);
      4:       v = '0 - VALUE_BITS'($urandom_range(1, 40));
      5:       v = $urandom >> $urandom_range(0, 31);
      6: begin
        case ($urandom_range(0, 4))
          0:       v = '0;
          1:       v = 1;
          2:       v = {1'b0, {(VALUE_BITS-1){1'b1}}};
          3:       v = {1'b1, {(VALUE_BITS-1){1'b0}}};
          default: v = '1;
        endcase
      end
      default: v = $urandom | {1'b1, {(VALUE_BITS-1){1'b0}}};
    endcase
    return v;
  endfunction

  function automatic logic [GLYPHS_W-1:0] pick_glyph_word(input bit high);
    case ($urandom_range(0, 2))
      0:       return {$urandom, $urandom};
      1:       return high ? HEX_UPPER_HIGH : GLYPHS_LOW_RESET;
      default: return high ? HEX_LOWER_HIGH : GLYPHS_LOW_RESET;
    endcase
  endfunction

  // Expected characters for one number under the current register copy.
  function automatic void predict_text(input logic kind, input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] rem;
    logic [RADIX_W-1:0]    base;
    logic [DIGIT_W-1:0]    digits[VALUE_BITS];
    logic [2*GLYPHS_W-1:0] glyph_table;
    int                    nd;
    base = radix_reg;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    glyph_table = {glyphs_hi_reg, glyphs_lo_reg};
    mag = value;
    if (kind == KIND_SIGNED && value[VALUE_BITS-1]) begin
      pending_chars.push_back('{glyph: MINUS_GLYPH, last: 1'b0});
      mag = ~value + 1'b1;
    end
    nd = 0;
    if (mag == '0) begin
      digits[0] = '0;
      nd = 1;
    end else begin
      while (mag != '0) begin
        rem = mag % VALUE_BITS'(base);
        digits[nd] = rem[DIGIT_W-1:0];
        mag = mag / VALUE_BITS'(base);
        nd++;
      end
    end
    for (int k = nd - 1; k >= 0; k--) begin
      pending_chars.push_back('{glyph: glyph_table[digits[k]*GLYPH_W +: GLYPH_W],
                                last: (k == 0)});
    end
  endfunction

  task automatic send_item(input logic kind, input logic [VALUE_BITS-1:0] value,
                           input string text);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.kind  <= kind;
    in_chan.value <= value;
    do @(posedge clk); while (!in_chan.ready);
    if (text.len() > 0) begin
      for (int i = 0; i < text.len(); i++) begin
        pending_chars.push_back('{glyph: text[i], last: (i == text.len() - 1)});
      end
    end else begin
      predict_text(kind, value);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [GLYPHS_W-1:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      CFG_RADIX:       radix_reg = data[RADIX_W-1:0];
      CFG_GLYPHS_LOW:  glyphs_lo_reg = data;
      CFG_GLYPHS_HIGH: glyphs_hi_reg = data;
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    in_chan.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (steady) begin
      out_chan.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left     <= stall_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          stall_left     <= $urandom_range(8, 40);
          out_chan.ready <= 1'b0;
        end
        1, 2, 3, 4: begin
          stall_left     <= $urandom_range(0, 2);
          out_chan.ready <= 1'b0;
        end
        default: out_chan.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin : text_checker
    text_char_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected transfer: glyph %h last %b", out_chan.glyph, out_chan.last);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_chan.glyph !== want.glyph) begin
          $error("glyph mismatch: expected %h, got %h", want.glyph, out_chan.glyph);
          error_count++;
        end
        if (out_chan.last !== want.last) begin
          $error("last mismatch: expected %b, got %b", want.last, out_chan.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t             row;
    bit                    writing;
    logic [GLYPHS_W-1:0]   radix_data;

    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.kind   = KIND_SIGNED;
    in_chan.value  = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_RADIX;
    cfg_chan.data  = '0;
    radix_reg      = RADIX_RESET;
    glyphs_lo_reg  = GLYPHS_LOW_RESET;
    glyphs_hi_reg  = GLYPHS_HIGH_RESET;

    directed_rows = '{
      '{1'b0, CFG_RADIX, 64'd0, KIND_UNSIGNED, 32'h0000_0000, "0"},
      '{1'b0, CFG_RADIX, 64'd0, KIND_SIGNED,   32'h0000_0000, "0"},
      '{1'b0, CFG_RADIX, 64'd0, KIND_UNSIGNED, 32'hFFFF_FFFF, "4294967295"},
      '{1'b0, CFG_RADIX, 64'd0, KIND_SIGNED,   32'hFFFF_FFFF, "-1"},
      '{1'b0, CFG_RADIX, 64'd0, KIND_SIGNED,   32'h8000_0000, "-2147483648"},
      '{1'b0, CFG_RADIX, 64'd0, KIND_SIGNED,   32'h7FFF_FFFF, "2147483647"},
      '{1'b0, CFG_RADIX, 64'd0, KIND_UNSIGNED, 32'h8000_0000, "2147483648"},
      '{1'b0, CFG_RADIX, 64'd0, KIND_UNSIGNED, 32'h0000_0001, "1"},
      '{1'b1, CFG_GLYPHS_HIGH, HEX_UPPER_HIGH, KIND_SIGNED, 32'h0, ""},
      '{1'b1, CFG_RADIX, 64'd16, KIND_SIGNED, 32'h0, ""},
      '{1'b0, CFG_RADIX, 64'd0, KIND_UNSIGNED, 32'hFFFF_FFFF, "FFFFFFFF"},
      '{1'b0, CFG_RADIX, 64'd0, KIND_SIGNED,   32'h8000_0000, "-80000000"},
      '{1'b0, CFG_RADIX, 64'd0, KIND_UNSIGNED, 32'hDEAD_BEEF, "DEADBEEF"},
      '{1'b1, CFG_RADIX, 64'd2, KIND_SIGNED, 32'h0, ""},
      '{1'b0, CFG_RADIX, 64'd0, KIND_SIGNED,   32'h8000_0000, ""},
      '{1'b0, CFG_RADIX, 64'd0, KIND_UNSIGNED, 32'hFFFF_FFFF, ""},
      '{1'b0, CFG_RADIX, 64'd0, KIND_UNSIGNED, 32'h0000_0005, "101"},
      '{1'b1, CFG_RADIX, 64'd0, KIND_SIGNED, 32'h0, ""},
      '{1'b0, CFG_RADIX, 64'd0, KIND_UNSIGNED, 32'h0000_0006, "110"},
      '{1'b1, CFG_RADIX, 64'd1, KIND_SIGNED, 32'h0, ""},
      '{1'b0, CFG_RADIX, 64'd0, KIND_SIGNED,   32'hFFFF_FFFB, "-101"},
      '{1'b1, CFG_RADIX, 64'd17, KIND_SIGNED, 32'h0, ""},
      '{1'b0, CFG_RADIX, 64'd0, KIND_UNSIGNED, 32'h0000_ABCD, "ABCD"},
      '{1'b1, CFG_RADIX, 64'hFFFF_FFFF_FFFF_FFFF, KIND_SIGNED, 32'h0, ""},
      '{1'b0, CFG_RADIX, 64'd0, KIND_UNSIGNED, 32'h1234_5678, "12345678"},
      // minus sign sitting in the digit table
      '{1'b1, CFG_GLYPHS_LOW, 64'h3736_3534_3332_2D30, KIND_SIGNED, 32'h0, ""},
      '{1'b1, CFG_RADIX, 64'd3, KIND_SIGNED, 32'h0, ""},
      '{1'b0, CFG_RADIX, 64'd0, KIND_SIGNED,   32'h8000_0000, ""},
      '{1'b0, CFG_RADIX, 64'd0, KIND_UNSIGNED, 32'hFFFF_FFFF, ""},
      '{1'b0, CFG_RADIX, 64'd0, KIND_UNSIGNED, 32'h0000_0004, ""},
      '{1'b1, CFG_GLYPHS_LOW, 64'hFFFF_FFFF_FFFF_FFFF, KIND_SIGNED, 32'h0, ""},
      '{1'b1, CFG_GLYPHS_HIGH, 64'h0, KIND_SIGNED, 32'h0, ""},
      '{1'b1, CFG_RADIX, 64'd16, KIND_SIGNED, 32'h0, ""},
      '{1'b0, CFG_RADIX, 64'd0, KIND_UNSIGNED, 32'hF0F0_F0F0, ""},
      '{1'b0, CFG_RADIX, 64'd0, KIND_SIGNED,   32'h075B_CD15, ""}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    writing = 1'b0;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_write) begin
        if (!writing) wait_drain();
        write_reg(row.reg_idx, row.data);
        writing = 1'b1;
      end else begin
        if (writing) cfg_chan.valid <= 1'b0;
        writing = 1'b0;
        send_item(row.kind, row.value, row.text);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drain();
      steady = (phase == 3);
      radix_data = {$urandom, $urandom};
      case (phase)
        0:       radix_data[RADIX_W-1:0] = 5'd2;
        1:       radix_data[RADIX_W-1:0] = 5'd16;
        2:       radix_data[RADIX_W-1:0] = 5'd10;
        3:       radix_data[RADIX_W-1:0] = 5'd31;
        4:       radix_data[RADIX_W-1:0] = 5'd7;
        default: radix_data[RADIX_W-1:0] = RADIX_W'($urandom_range(0, 31));
      endcase
      write_reg(CFG_RADIX, radix_data);
      write_reg(CFG_GLYPHS_LOW, pick_glyph_word(1'b0));
      write_reg(CFG_GLYPHS_HIGH, pick_glyph_word(1'b1));
      cfg_chan.valid <= 1'b0;
      repeat (ITEMS_PER_PHASE) begin
        send_item(1'($urandom_range(0, 1)), pick_value(), "");
      end
    end

    wait_drain();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
